// ===== hdl/zfc_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
package zfc_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int FRAC_W       = 8;
  localparam int MEAN_W       = 41;
  localparam int MAG_W        = 41;
  localparam int HALF_W       = (MAG_W + 1) / 2;
  localparam int OUT_W        = 40;
  localparam int CNT_W        = 8;
  localparam int THR_W        = 16;
  localparam int SIGMA_W      = 31;
  localparam int MAX_DAYS_DEF = 128;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd819;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 31'd1;

  localparam logic [1:0] REG_MEAN  = 2'd0;
  localparam logic [1:0] REG_SIGMA = 2'd1;
  localparam logic [1:0] REG_THR   = 2'd2;
  localparam logic [1:0] REG_CONS  = 2'd3;

  // Partial product selects for the split magnitude square.
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mdiv_start;
    logic       mean_latch;
    logic       rd;
    logic       idx_clr;
    logic       idx_inc;
    logic       acc_clr;
    logic       d_load;
    logic       pp_load;
    logic [1:0] pp_sel;
    logic       acc_add;
    logic       vdiv_start;
    logic       sqrt_start;
    logic       rms_latch;
    logic       rms_clr;
    logic       prod_load;
    logic       cnt_clr;
    logic       cnt_eval;
    logic       publish;
  } zfc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic idx_last;
    logic multi;
    logic out_full;
  } zfc_status_t;

endpackage

// ===== hdl/zfc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module zfc_div #(
  parameter int DVW = 90,
  parameter int DSW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic [DVW-1:0] quo,
  output logic [DSW-1:0] rem,
  output logic           done
);
  localparam int CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  q;
  logic [DSW-1:0]  r;
  logic [DSW-1:0]  d;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DSW:0]    r_sh;
  logic [DSW:0]    diff;
  logic            ge;

  always_comb begin
    r_sh = {r, q[DVW-1]};
    ge   = r_sh >= {1'b0, d};
    diff = r_sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DVW);
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        q   <= {q[DVW-2:0], ge};
        r   <= ge ? diff[DSW-1:0] : r_sh[DSW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r;

endmodule

// ===== hdl/zfc_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module zfc_isqrt #(
  parameter int RW = 45
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root,
  output logic            done
);
  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] v;
  logic [RW+1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem, v[2*RW-1:2*RW-2]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(RW);
        v    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        v    <= {v[2*RW-3:0], 2'b00};
        rem  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root <= {root[RW-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/zfc_datapath.sv =====
// Sample store, sums, shared divider and root, threshold counters, result register.
module zfc_datapath #(
  parameter int MAX_DAYS = zfc_pkg::MAX_DAYS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  zfc_pkg::zfc_cmd_t                    cmd,
  output zfc_pkg::zfc_status_t                 status,
  input  logic signed [zfc_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [zfc_pkg::SAMPLE_W-1:0]  ref_mean,
  input  logic [zfc_pkg::SIGMA_W-1:0]          ref_sigma,
  input  logic [zfc_pkg::THR_W-1:0]            thr,
  input  logic                                 cons_en,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [zfc_pkg::OUT_W-1:0]     mean_q8,
  output logic [zfc_pkg::OUT_W-1:0]            rms_q8,
  output logic [zfc_pkg::CNT_W-1:0]            count_above_computed,
  output logic [zfc_pkg::CNT_W-1:0]            count_above_reference,
  output logic                                 pair_adjacent,
  output logic                                 triple_adjacent
);
  import zfc_pkg::*;

  localparam int AW   = $clog2(MAX_DAYS);
  localparam int CW   = $clog2(MAX_DAYS + 1);
  localparam int SW   = SAMPLE_W + CW;
  localparam int SQW  = 2 * MAG_W + CW;
  localparam int RW   = (SQW + 1) / 2;
  localparam int PCW  = THR_W + RW;
  localparam int CMPW = PCW + 1;
  localparam int DW   = MEAN_W + 1;
  localparam int PRW  = THR_W + SIGMA_W;
  localparam int RCW  = PRW + 2;

  logic signed [SAMPLE_W-1:0] mem [MAX_DAYS];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [CW-1:0]              count;
  logic [AW-1:0]              idx;
  logic signed [SW-1:0]       sum;
  logic signed [MEAN_W-1:0]   mean;
  logic [MAG_W-1:0]           dmag;
  logic [SQW-1:0]             pp;
  logic [SQW-1:0]             acc;
  logic [RW-1:0]              rms;
  logic [PCW-1:0]             prod_c;
  logic [PRW-1:0]             prod_r;
  logic                       stats_ok;
  logic [CNT_W-1:0]           cnt_c;
  logic [CNT_W-1:0]           cnt_r;
  logic                       p1;
  logic                       p2;
  logic                       pair_f;
  logic                       triple_f;

  logic                       full;
  logic signed [SW+FRAC_W-1:0] scaled;
  logic [SQW-1:0]             div_dividend;
  logic [CW-1:0]              div_divisor;
  logic [SQW-1:0]             quo;
  logic [CW-1:0]              rem;
  logic                       div_done;
  logic [RW-1:0]              root;
  logic                       sqrt_done;
  logic [MEAN_W-1:0]          q_low;
  logic signed [DW-1:0]       d;
  logic [HALF_W-1:0]          al;
  logic [HALF_W-1:0]          ah;
  logic [HALF_W-1:0]          op_a;
  logic [HALF_W-1:0]          op_b;
  logic [2*HALF_W-1:0]        prod;
  logic [SQW-1:0]             pp_next;
  logic signed [CMPW-1:0]     lhs_c;
  logic signed [RCW-1:0]      lhs_r;
  logic signed [SAMPLE_W:0]   dr;
  logic                       hit_c;
  logic                       hit_r;

  assign full   = count == CW'(MAX_DAYS);
  assign scaled = {sum, {FRAC_W{1'b0}}};
  assign q_low  = quo[MEAN_W-1:0];

  always_comb begin
    if (cmd.vdiv_start) begin
      div_dividend = acc;
      div_divisor  = count - 1'b1;
    end else begin
      div_dividend = SQW'(scaled[SW+FRAC_W-1] ? -scaled : scaled);
      div_divisor  = count;
    end
  end

  zfc_div #(.DVW(SQW), .DSW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mdiv_start | cmd.vdiv_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (quo),
    .rem      (rem),
    .done     (div_done)
  );

  zfc_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand ((2*RW)'(quo)),
    .root     (root),
    .done     (sqrt_done)
  );

  // Deviation of the stored sample from the computed mean, Q8.
  always_comb begin
    d  = DW'($signed({rd_data, {FRAC_W{1'b0}}})) - DW'(mean);
    al = dmag[HALF_W-1:0];
    ah = HALF_W'(dmag[MAG_W-1:HALF_W]);
    unique case (cmd.pp_sel)
      PP_LL: begin op_a = al; op_b = al; end
      PP_LH: begin op_a = al; op_b = ah; end
      PP_HL: begin op_a = ah; op_b = al; end
      PP_HH: begin op_a = ah; op_b = ah; end
      default: begin op_a = al; op_b = al; end
    endcase
    prod = op_a * op_b;
    unique case (cmd.pp_sel)
      PP_LL:   pp_next = SQW'(prod);
      PP_LH:   pp_next = SQW'(prod) << HALF_W;
      PP_HL:   pp_next = SQW'(prod) << HALF_W;
      PP_HH:   pp_next = SQW'(prod) << (2 * HALF_W);
      default: pp_next = SQW'(prod);
    endcase
    lhs_c = CMPW'($signed({d, {FRAC_W{1'b0}}}));
    hit_c = stats_ok && (lhs_c >= $signed({1'b0, prod_c}));
    dr    = {rd_data[SAMPLE_W-1], rd_data} - {ref_mean[SAMPLE_W-1], ref_mean};
    lhs_r = RCW'($signed({dr, {FRAC_W{1'b0}}}));
    hit_r = lhs_r >= $signed({2'b00, prod_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= sample;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        count     <= '0;
        sum       <= '0;
        out_valid <= 1'b1;
      end else begin
        if (cmd.load && !full) begin
          count <= count + 1'b1;
          sum   <= sum + SW'(sample);
        end
        if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_latch) begin
      if (scaled[SW+FRAC_W-1]) begin
        mean <= -$signed(q_low + MEAN_W'(rem != '0));
      end else begin
        mean <= $signed(q_low);
      end
    end
    if (cmd.d_load) begin
      dmag <= d[DW-1] ? MAG_W'(-d) : MAG_W'(d);
    end
    if (cmd.pp_load) begin
      pp <= pp_next;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + pp;
    end
    if (cmd.rms_clr) begin
      rms <= '0;
    end else if (cmd.rms_latch) begin
      rms <= root;
    end
    if (cmd.prod_load) begin
      prod_c   <= thr * rms;
      prod_r   <= thr * ref_sigma;
      stats_ok <= (count > CW'(1)) && (rms != '0);
    end
    if (cmd.cnt_clr) begin
      cnt_c    <= '0;
      cnt_r    <= '0;
      p1       <= 1'b0;
      p2       <= 1'b0;
      pair_f   <= 1'b0;
      triple_f <= 1'b0;
    end else if (cmd.cnt_eval) begin
      if (hit_c) begin
        if (cnt_c != '1) cnt_c <= cnt_c + 1'b1;
        if (p1) pair_f <= 1'b1;
        if (p1 && p2) triple_f <= 1'b1;
      end
      if (hit_r && cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
      p2 <= p1;
      p1 <= hit_c;
    end
    if (cmd.publish) begin
      mean_q8               <= mean[OUT_W-1:0];
      rms_q8                <= rms[OUT_W-1:0];
      count_above_computed  <= cnt_c;
      count_above_reference <= cnt_r;
      pair_adjacent         <= cons_en && (cnt_c == CNT_W'(2)) && pair_f;
      triple_adjacent       <= cons_en && (cnt_c == CNT_W'(3)) && triple_f;
    end
  end

  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;
  assign status.idx_last  = CW'(idx) == count - 1'b1;
  assign status.multi     = count > CW'(1);
  assign status.out_full  = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_publish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid && (count == '0))
    else $error("publish did not present a result and clear the curve");
  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !full && !cmd.publish) |=> count == $past(count) + 1'b1)
    else $error("stored sample not counted");
  a_no_stats_no_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_eval && !cmd.cnt_clr && !stats_ok) |=> cnt_c == $past(cnt_c))
    else $error("computed count moved without valid statistics");
`endif

endmodule

// ===== hdl/zfc_ctrl.sv =====
// Sequencer for load, mean, variance, root and counting passes.
module zfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last,
  output logic                 in_ready,
  input  zfc_pkg::zfc_status_t status,
  output zfc_pkg::zfc_cmd_t    cmd
);
  import zfc_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_MSTART = 4'd1;
  localparam logic [3:0] S_MWAIT  = 4'd2;
  localparam logic [3:0] S_SQ     = 4'd3;
  localparam logic [3:0] S_VSTART = 4'd4;
  localparam logic [3:0] S_VWAIT  = 4'd5;
  localparam logic [3:0] S_SWAIT  = 4'd6;
  localparam logic [3:0] S_PROD   = 4'd7;
  localparam logic [3:0] S_CNT    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] ph;
  logic [2:0] ph_next;

  assign in_ready = state == S_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    ph_next    = ph;
    unique case (state)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && last) state_next = S_MSTART;
      end
      S_MSTART: begin
        cmd.mdiv_start = 1'b1;
        state_next     = S_MWAIT;
      end
      S_MWAIT: begin
        if (status.div_done) begin
          cmd.mean_latch = 1'b1;
          cmd.idx_clr    = 1'b1;
          cmd.acc_clr    = 1'b1;
          ph_next        = 3'd0;
          if (status.multi) begin
            state_next = S_SQ;
          end else begin
            cmd.rms_clr = 1'b1;
            state_next  = S_PROD;
          end
        end
      end
      S_SQ: begin
        ph_next = ph + 1'b1;
        unique case (ph)
          3'd0: cmd.rd = 1'b1;
          3'd1: cmd.d_load = 1'b1;
          3'd2: begin cmd.pp_load = 1'b1; cmd.pp_sel = PP_LL; end
          3'd3: begin cmd.pp_load = 1'b1; cmd.pp_sel = PP_LH; cmd.acc_add = 1'b1; end
          3'd4: begin cmd.pp_load = 1'b1; cmd.pp_sel = PP_HL; cmd.acc_add = 1'b1; end
          3'd5: begin cmd.pp_load = 1'b1; cmd.pp_sel = PP_HH; cmd.acc_add = 1'b1; end
          3'd6: begin
            cmd.acc_add = 1'b1;
            ph_next     = 3'd0;
            if (status.idx_last) state_next = S_VSTART;
            else cmd.idx_inc = 1'b1;
          end
          default: ph_next = 3'd0;
        endcase
      end
      S_VSTART: begin
        cmd.vdiv_start = 1'b1;
        state_next     = S_VWAIT;
      end
      S_VWAIT: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (status.sqrt_done) begin
          cmd.rms_latch = 1'b1;
          state_next    = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod_load = 1'b1;
        cmd.idx_clr   = 1'b1;
        cmd.cnt_clr   = 1'b1;
        ph_next       = 3'd0;
        state_next    = S_CNT;
      end
      S_CNT: begin
        if (ph == 3'd0) begin
          cmd.rd  = 1'b1;
          ph_next = 3'd1;
        end else begin
          cmd.cnt_eval = 1'b1;
          ph_next      = 3'd0;
          if (status.idx_last) state_next = S_DONE;
          else cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.publish = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      ph    <= '0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_mean_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.mean_latch |-> status.div_done && $past(state) == S_MWAIT || state == S_MWAIT)
    else $error("mean latched without a finished division");
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> state == S_MSTART)
    else $error("last item did not start the statistics");
  a_publish_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> in_ready)
    else $error("block did not return to loading after a result");
`endif

endmodule

// ===== hdl/zscore_flare_counter_top.sv =====
// Top level of the flare counter: configuration registers, controller and datapath.
// The block takes one light curve as a stream of signed flux items, one item per cycle,
// into a MAX_DAYS-entry sample memory; items past MAX_DAYS are dropped, but a last item
// still closes the curve. After the item marked last the block is busy: a serial
// divider forms the Q8 mean; for more than one sample, a pass over the memory sums
// squared deviations, reading each sample in turn, through a split 21-bit multiplier,
// the same divider then divides by count minus one and a bit-serial square root follows;
// a final pass then counts threshold crossings, reading each sample in turn. The loading
// of the next curve starts as soon as the result sits in the output register. The four
// configuration registers sit on an APB-style port at byte addresses 0, 4, 8 and 12
// and are meant to be written only while no curve is in progress.
module zscore_flare_counter_top #(
  parameter int MAX_DAYS = zfc_pkg::MAX_DAYS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [zfc_pkg::APB_AW-1:0]           paddr,
  input  logic [zfc_pkg::APB_DW-1:0]           pwdata,
  output logic [zfc_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [zfc_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [zfc_pkg::OUT_W-1:0]     mean_q8,
  output logic [zfc_pkg::OUT_W-1:0]            rms_q8,
  output logic [zfc_pkg::CNT_W-1:0]            count_above_computed,
  output logic [zfc_pkg::CNT_W-1:0]            count_above_reference,
  output logic                                 pair_adjacent,
  output logic                                 triple_adjacent
);
  import zfc_pkg::*;

  logic signed [SAMPLE_W-1:0] reference_mean;
  logic [SIGMA_W-1:0]         reference_sigma;
  logic [THR_W-1:0]           threshold_q8;
  logic                       consecutive_enable;
  logic                       wr_en;
  logic [1:0]                 reg_idx;
  zfc_cmd_t                   cmd;
  zfc_status_t                status;

  // Registers are word aligned; the low two address bits are ignored.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mean     <= '0;
      reference_sigma    <= SIGMA_RESET;
      threshold_q8       <= THR_RESET;
      consecutive_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MEAN:  reference_mean     <= $signed(pwdata);
        REG_SIGMA: reference_sigma    <= pwdata[SIGMA_W-1:0];
        REG_THR:   threshold_q8       <= pwdata[THR_W-1:0];
        REG_CONS:  consecutive_enable <= pwdata[0];
        default:   reference_mean     <= reference_mean;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MEAN:  prdata = reference_mean;
      REG_SIGMA: prdata = APB_DW'(reference_sigma);
      REG_THR:   prdata = APB_DW'(threshold_q8);
      REG_CONS:  prdata = APB_DW'(consecutive_enable);
      default:   prdata = '0;
    endcase
  end

  zfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  zfc_datapath #(.MAX_DAYS(MAX_DAYS)) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .sample                (sample),
    .ref_mean              (reference_mean),
    .ref_sigma             (reference_sigma),
    .thr                   (threshold_q8),
    .cons_en               (consecutive_enable),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .mean_q8               (mean_q8),
    .rms_q8                (rms_q8),
    .count_above_computed  (count_above_computed),
    .count_above_reference (count_above_reference),
    .pair_adjacent         (pair_adjacent),
    .triple_adjacent       (triple_adjacent)
  );

endmodule
